[hw/rtl/icr_pkg.sv]
package icr_pkg;

  localparam int unsigned TABLE_ENTRIES = 8;
  localparam int unsigned DATA_W        = 64;
  localparam int unsigned IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned CNT_W         = $clog2(TABLE_ENTRIES + 1);
  localparam int unsigned ENTRY_W       = 2 * DATA_W;

  typedef logic [DATA_W-1:0] word_t;
  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [CNT_W-1:0]  cnt_t;

  localparam cnt_t CNT_FULL = cnt_t'(TABLE_ENTRIES);

  typedef enum logic [1:0] {
    OP_ADD      = 2'd0,
    OP_SATURATE = 2'd1,
    OP_DRAIN    = 2'd2
  } icr_op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_APPEND,
    ST_DRAIN
  } icr_state_t;

  typedef struct packed {
    logic latch_in;
    logic ptr_clr;
    logic ptr_inc;
    logic wr_grow_end;
    logic wr_grow_begin;
    logic wr_append;
    logic cnt_clr;
    logic cnt_fill;
    logic emit_entry;
    logic emit_last;
    logic emit_flush;
    logic emit_empty;
  } icr_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic last_entry;
    logic hit_end;
    logic hit_begin;
  } icr_stat_t;

endpackage

[hw/rtl/icr_ram.sv]
module icr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 8
) (
  input  logic                                        clk,
  input  logic                                        wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                            wr_data,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                            rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

[hw/rtl/icr_ctrl.sv]
module icr_ctrl import icr_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  logic [1:0] in_cmd,
  input  icr_stat_t stat,
  output icr_cmd_t  cmd,
  output logic      busy
);

  icr_state_t state_r, state_nxt;
  logic       accept;

  assign accept = start && (state_r == ST_IDLE);
  assign busy   = (state_r != ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (in_cmd)
            OP_ADD: begin
              if (stat.full) begin
                state_nxt = ST_IDLE;
              end else if (stat.empty) begin
                state_nxt = ST_APPEND;
              end else begin
                state_nxt = ST_SCAN;
              end
            end
            OP_DRAIN: begin
              if (!stat.full && !stat.empty) begin
                state_nxt = ST_DRAIN;
              end
            end
            default: state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_SCAN: begin
        if (stat.hit_end || stat.hit_begin || stat.last_entry) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_APPEND: state_nxt = ST_IDLE;
      ST_DRAIN: begin
        if (stat.last_entry) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          cmd.latch_in = 1'b1;
          cmd.ptr_clr  = 1'b1;
          case (in_cmd)
            OP_SATURATE: cmd.cnt_fill = 1'b1;
            OP_DRAIN: begin
              if (stat.full) begin
                cmd.emit_flush = 1'b1;
                cmd.cnt_clr    = 1'b1;
              end else if (stat.empty) begin
                cmd.emit_empty = 1'b1;
              end
            end
            default: cmd.cnt_clr = 1'b0;
          endcase
        end
      end
      ST_SCAN: begin
        // The end-of-entry test wins over the start-of-entry test on the same entry.
        if (stat.hit_end) begin
          cmd.wr_grow_end = 1'b1;
        end else if (stat.hit_begin) begin
          cmd.wr_grow_begin = 1'b1;
        end else if (stat.last_entry) begin
          cmd.wr_append = 1'b1;
        end else begin
          cmd.ptr_inc = 1'b1;
        end
      end
      ST_APPEND: cmd.wr_append = 1'b1;
      ST_DRAIN: begin
        cmd.emit_entry = 1'b1;
        cmd.emit_last  = stat.last_entry;
        cmd.cnt_clr    = stat.last_entry;
        cmd.ptr_inc    = !stat.last_entry;
      end
      default: cmd = '0;
    endcase
  end

endmodule

[hw/rtl/icr_dp.sv]
module icr_dp import icr_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  icr_cmd_t  cmd,
  input  word_t     in_range_start,
  input  word_t     in_range_size,
  output icr_stat_t stat,
  output logic      out_valid,
  output word_t     out_start,
  output word_t     out_size,
  output logic      out_flush_all,
  output logic      out_has_range,
  output logic      out_last
);

  word_t base_r, len_r, end_r;
  cnt_t  count_r, count_nxt;
  idx_t  ptr_r, ptr_nxt;

  logic               wr_en;
  idx_t               wr_addr;
  logic [ENTRY_W-1:0] wr_data;
  logic [ENTRY_W-1:0] rd_data;
  word_t              ent_start, ent_size;

  logic  out_valid_r, out_flush_r, out_has_r, out_last_r;
  word_t out_start_r, out_size_r;

  assign ent_start = rd_data[ENTRY_W-1:DATA_W];
  assign ent_size  = rd_data[DATA_W-1:0];

  always_comb begin
    ptr_nxt = ptr_r;
    if (cmd.ptr_clr) begin
      ptr_nxt = '0;
    end else if (cmd.ptr_inc) begin
      ptr_nxt = idx_t'(ptr_r + idx_t'(1));
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (cmd.cnt_clr) begin
      count_nxt = '0;
    end else if (cmd.cnt_fill) begin
      count_nxt = CNT_FULL;
    end else if (cmd.wr_append) begin
      count_nxt = cnt_t'(count_r + cnt_t'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      ptr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      ptr_r       <= ptr_nxt;
      out_valid_r <= cmd.emit_entry || cmd.emit_flush || cmd.emit_empty;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      base_r <= in_range_start;
      len_r  <= in_range_size;
      end_r  <= in_range_start + in_range_size;
    end
    if (cmd.emit_entry) begin
      out_start_r <= ent_start;
      out_size_r  <= ent_size;
      out_flush_r <= 1'b0;
      out_has_r   <= 1'b1;
      out_last_r  <= cmd.emit_last;
    end else if (cmd.emit_flush || cmd.emit_empty) begin
      out_start_r <= '0;
      out_size_r  <= '0;
      out_flush_r <= cmd.emit_flush;
      out_has_r   <= 1'b0;
      out_last_r  <= 1'b1;
    end
  end

  always_comb begin
    wr_en   = cmd.wr_grow_end || cmd.wr_grow_begin || cmd.wr_append;
    wr_addr = ptr_r;
    wr_data = {base_r, len_r};
    if (cmd.wr_grow_end) begin
      wr_data = {ent_start, ent_size + len_r};
    end else if (cmd.wr_grow_begin) begin
      wr_data = {ent_start - len_r, ent_size + len_r};
    end else begin
      wr_addr = idx_t'(count_r);
    end
  end

  // Reads are addressed with ptr_nxt through the registered read port, so the entry at ptr_r is on rd_data.
  icr_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_ENTRIES)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (ptr_nxt),
    .rd_data (rd_data)
  );

  assign stat.full       = (count_r == CNT_FULL);
  assign stat.empty      = (count_r == '0);
  assign stat.last_entry = (cnt_t'(cnt_t'(ptr_r) + cnt_t'(1)) == count_r);
  assign stat.hit_end    = (base_r == ent_start + ent_size);
  assign stat.hit_begin  = (end_r == ent_start);

  assign out_valid     = out_valid_r;
  assign out_start     = out_start_r;
  assign out_size      = out_size_r;
  assign out_flush_all = out_flush_r;
  assign out_has_range = out_has_r;
  assign out_last      = out_last_r;

endmodule

[hw/rtl/invalidation_range_coalescer.sv]
// Channel  | Ports                                         | Handshake
// command  | in_cmd, in_range_start, in_range_size         | start high while busy low
// result   | out_start, out_size, out_flush_all,           | out_valid marks each beat
//          | out_has_range, out_last                       |
//
// An add into an empty table goes straight to the append; otherwise it scans the stored
// entries in order (at most TABLE_ENTRIES - 1), the table RAM giving one entry a cycle.
// A drain of n stored ranges gives n beats, each registered before it shows on the ports;
// saturate, a dropped add and a drain of a full or empty table are handled when accepted and leave busy low.
// Reset is synchronous and active low and empties the table at once.
// Result beats cannot be stalled; a new command may be taken while the final
// beat of a drain is still on the result ports.
module invalidation_range_coalescer import icr_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_cmd,
  input  logic [63:0] in_range_start,
  input  logic [63:0] in_range_size,
  output logic        out_valid,
  output logic [63:0] out_start,
  output logic [63:0] out_size,
  output logic        out_flush_all,
  output logic        out_has_range,
  output logic        out_last
);

  icr_cmd_t  cmd;
  icr_stat_t stat;

  icr_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .in_cmd (in_cmd),
    .stat   (stat),
    .cmd    (cmd),
    .busy   (busy)
  );

  icr_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .in_range_start (in_range_start),
    .in_range_size  (in_range_size),
    .stat           (stat),
    .out_valid      (out_valid),
    .out_start      (out_start),
    .out_size       (out_size),
    .out_flush_all  (out_flush_all),
    .out_has_range  (out_has_range),
    .out_last       (out_last)
  );

`ifndef SYNTHESIS
  a_busy_from_accept: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy) |-> $past(start))
    else $error("busy rose without an accepted command");

  a_full_drain_flush: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_cmd == OP_DRAIN && stat.full)
      |=> (out_valid && out_flush_all && out_last && !out_has_range))
    else $error("drain of a full table did not give a flush-all beat");

  a_more_beats_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last) |-> busy)
    else $error("drain stopped before its last beat");
`endif

endmodule
